[rtl/core/sttu_pkg.sv]
// Package for the session table idle timeout unit.
// Holds commands, sequencer states, control structs and field widths.
// No dependencies.
`default_nettype none

package sttu_pkg;

    localparam int SLOTS_DEF     = 8;
    localparam logic [31:0] TIMEOUT_RESET = 32'd3600;

    localparam int CMD_W   = 3;
    localparam int TIME_W  = 32;
    localparam int TOKEN_W = 64;
    localparam int SLOT_W  = 3;
    localparam int COUNT_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE      = 3'd0,
        CMD_VALIDATE    = 3'd1,
        CMD_DESTROY     = 3'd2,
        CMD_DESTROY_ALL = 3'd3,
        CMD_COUNT       = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic set;
        logic clr;
        logic clr_all;
    } t_valid_op;

    typedef struct packed {
        logic tok;
        logic la;
    } t_wr_op;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               evicted;
        logic [SLOT_W-1:0]  slot;
        logic               ok;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/sttu_store.sv]
// Session slot store: token and last-access memories plus valid flags.
// Registered read at one address, one write port. Depends on sttu_pkg.
`default_nettype none

module sttu_store
    import sttu_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [IW-1:0]      i_rd_addr,
    output logic      [TOKEN_W-1:0] o_rd_th,
    output logic      [TOKEN_W-1:0] o_rd_tl,
    output logic      [TIME_W-1:0]  o_rd_la,
    input  wire t_wr_op             i_wr_op,
    input  wire logic [IW-1:0]      i_wr_addr,
    input  wire logic [TOKEN_W-1:0] i_wr_th,
    input  wire logic [TOKEN_W-1:0] i_wr_tl,
    input  wire logic [TIME_W-1:0]  i_wr_la,
    input  wire t_valid_op          i_vop,
    input  wire logic [IW-1:0]      i_v_idx,
    output logic      [SLOTS-1:0]   o_valid
);

    logic [TOKEN_W-1:0] mem_th [SLOTS];
    logic [TOKEN_W-1:0] mem_tl [SLOTS];
    logic [TIME_W-1:0]  mem_la [SLOTS];
    logic [SLOTS-1:0]   r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_op.tok) begin
            mem_th[i_wr_addr] <= i_wr_th;
            mem_tl[i_wr_addr] <= i_wr_tl;
        end
        if (i_wr_op.la) begin
            mem_la[i_wr_addr] <= i_wr_la;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_th <= mem_th[i_rd_addr];
        o_rd_tl <= mem_tl[i_rd_addr];
        o_rd_la <= mem_la[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_vop.clr_all) begin
            r_valid <= '0;
        end else if (i_vop.set) begin
            r_valid[i_v_idx] <= 1'b1;
        end else if (i_vop.clr) begin
            r_valid[i_v_idx] <= 1'b0;
        end
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

[rtl/core/sttu_ctrl.sv]
// Sequencer for the session table: scans slots through one idle-time and
// compare unit, then commits the command. Depends on sttu_pkg.
`default_nettype none

module sttu_ctrl
    import sttu_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [CMD_W-1:0]   i_cmd,
    input  wire logic [TIME_W-1:0]  i_now,
    input  wire logic [TOKEN_W-1:0] i_th,
    input  wire logic [TOKEN_W-1:0] i_tl,
    input  wire logic [TIME_W-1:0]  i_timeout,
    input  wire logic               i_out_free,
    output logic                    o_idle,
    output logic                    o_res_valid,
    output t_result                 o_res,
    output logic      [IW-1:0]      o_rd_addr,
    input  wire logic [TOKEN_W-1:0] i_rd_th,
    input  wire logic [TOKEN_W-1:0] i_rd_tl,
    input  wire logic [TIME_W-1:0]  i_rd_la,
    input  wire logic [SLOTS-1:0]   i_valid,
    output t_wr_op                  o_wr_op,
    output logic      [IW-1:0]      o_wr_addr,
    output logic      [TOKEN_W-1:0] o_wr_th,
    output logic      [TOKEN_W-1:0] o_wr_tl,
    output logic      [TIME_W-1:0]  o_wr_la,
    output t_valid_op               o_vop,
    output logic      [IW-1:0]      o_v_idx
);

    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] ADDR_END = CW'(SLOTS);
    localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_addr, n_addr;
    logic               r_pv, n_pv;
    logic [IW-1:0]      r_pidx, n_pidx;
    logic               r_free_found, n_free_found;
    logic [IW-1:0]      r_free_idx, n_free_idx;
    logic [TIME_W-1:0]  r_min_la, n_min_la;
    logic [IW-1:0]      r_min_idx, n_min_idx;
    logic               r_found, n_found;
    logic [IW-1:0]      r_fidx, n_fidx;
    logic               r_fidle, n_fidle;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    t_result            r_res, n_res;

    logic [CMD_W-1:0]   r_cmd;
    logic [TIME_W-1:0]  r_now;
    logic [TOKEN_W-1:0] r_th;
    logic [TOKEN_W-1:0] r_tl;

    logic               cur_valid;
    logic               idle_hit;
    logic               live;
    logic               match;
    logic               scan_cmd;
    logic [IW-1:0]      create_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pv         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pv         <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_pidx       <= n_pidx;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_min_la     <= n_min_la;
        r_min_idx    <= n_min_idx;
        r_found      <= n_found;
        r_fidx       <= n_fidx;
        r_fidle      <= n_fidle;
        r_cnt        <= n_cnt;
        r_res        <= n_res;
        if (o_idle && i_start) begin
            r_cmd <= i_cmd;
            r_now <= i_now;
            r_th  <= i_th;
            r_tl  <= i_tl;
        end
    end

    assign cur_valid  = i_valid[r_pidx];
    assign idle_hit   = (r_now - i_rd_la) > i_timeout;
    assign live       = cur_valid && !idle_hit;
    assign match      = cur_valid && (i_rd_th == r_th) && (i_rd_tl == r_tl);
    assign scan_cmd   = (i_cmd == CMD_CREATE) || (i_cmd == CMD_VALIDATE) ||
                        (i_cmd == CMD_DESTROY) || (i_cmd == CMD_COUNT);
    assign create_idx = r_free_found ? r_free_idx : r_min_idx;

    assign o_idle      = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_OUT);
    assign o_res       = r_res;
    assign o_rd_addr   = (r_addr < ADDR_END) ? r_addr[IW-1:0] : '0;
    assign o_wr_th     = r_th;
    assign o_wr_tl     = r_tl;
    assign o_wr_la     = r_now;

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_pv         = 1'b0;
        n_pidx       = r_pidx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_min_la     = r_min_la;
        n_min_idx    = r_min_idx;
        n_found      = r_found;
        n_fidx       = r_fidx;
        n_fidle      = r_fidle;
        n_cnt        = r_cnt;
        n_res        = r_res;
        o_vop        = '0;
        o_v_idx      = r_pidx;
        o_wr_op      = '0;
        o_wr_addr    = create_idx;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state      = scan_cmd ? ST_SCAN : ST_FINISH;
                    n_addr       = '0;
                    n_free_found = 1'b0;
                    n_found      = 1'b0;
                    n_cnt        = '0;
                end
            end
            ST_SCAN: begin
                if (r_addr < ADDR_END) begin
                    n_addr = r_addr + CW'(1);
                    n_pv   = 1'b1;
                    n_pidx = r_addr[IW-1:0];
                end
                if (r_pv) begin
                    if (r_cmd == CMD_CREATE || r_cmd == CMD_COUNT) begin
                        if (cur_valid && idle_hit) begin
                            o_vop.clr = 1'b1;
                        end
                        if (r_cmd == CMD_CREATE) begin
                            if (!live && !r_free_found) begin
                                n_free_found = 1'b1;
                                n_free_idx   = r_pidx;
                            end
                            if (r_pidx == '0 || i_rd_la < r_min_la) begin
                                n_min_la  = i_rd_la;
                                n_min_idx = r_pidx;
                            end
                        end else if (live && r_cnt != '1) begin
                            n_cnt = r_cnt + COUNT_W'(1);
                        end
                    end else if (match && !r_found) begin
                        n_found = 1'b1;
                        n_fidx  = r_pidx;
                        n_fidle = idle_hit;
                    end
                    if (r_pidx == IDX_LAST) begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                n_res   = '0;
                n_state = ST_OUT;
                unique case (r_cmd)
                    CMD_CREATE: begin
                        o_vop.set     = 1'b1;
                        o_v_idx       = create_idx;
                        o_wr_op.tok   = 1'b1;
                        o_wr_op.la    = 1'b1;
                        o_wr_addr     = create_idx;
                        n_res.ok      = 1'b1;
                        n_res.slot    = SLOT_W'(create_idx);
                        n_res.evicted = !r_free_found;
                    end
                    CMD_VALIDATE: begin
                        if (r_found) begin
                            n_res.slot = SLOT_W'(r_fidx);
                            o_v_idx    = r_fidx;
                            o_wr_addr  = r_fidx;
                            if (r_fidle) begin
                                o_vop.clr = 1'b1;
                            end else begin
                                o_wr_op.la = 1'b1;
                                n_res.ok   = 1'b1;
                            end
                        end
                    end
                    CMD_DESTROY: begin
                        if (r_found) begin
                            o_v_idx    = r_fidx;
                            o_vop.clr  = 1'b1;
                            n_res.ok   = 1'b1;
                            n_res.slot = SLOT_W'(r_fidx);
                        end
                    end
                    CMD_DESTROY_ALL: begin
                        o_vop.clr_all = 1'b1;
                    end
                    CMD_COUNT: begin
                        n_res.count = r_cnt;
                    end
                    default: begin
                    end
                endcase
            end
            ST_OUT: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/session_table_idle_timeout_unit.sv]
// Session table with idle timeout: top level with stream ports, timeout
// register and output register. Depends on sttu_pkg, sttu_store, sttu_ctrl.
// One command at a time: the input is ready only while the sequencer is idle.
// Scanning commands walk every slot first; destroy-all and unknown ones do not.
// A stalled output holds the sequencer, and with it the next command.
// Reset clears all valid flags at once and loads the timeout with 3600.
`default_nettype none

module session_table_idle_timeout_unit
    import sttu_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [31:0]  i_cfg_data,      // idle_timeout_sec
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [159:0] i_s_axis_tdata,  // now_sec, token_high, token_low
    input  wire logic [2:0]   i_s_axis_tuser,  // cmd
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [15:0]       o_m_axis_tdata   // ok, slot, evicted, active_count, zero pad
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [TIME_W-1:0]  r_timeout;
    logic               r_m_tvalid;
    t_result            r_m_res;

    logic               start;
    logic               out_free;
    logic               idle;
    logic               res_valid;
    t_result            res;
    logic [IW-1:0]      rd_addr;
    logic [TOKEN_W-1:0] rd_th;
    logic [TOKEN_W-1:0] rd_tl;
    logic [TIME_W-1:0]  rd_la;
    logic [SLOTS-1:0]   valid;
    t_wr_op             wr_op;
    logic [IW-1:0]      wr_addr;
    logic [TOKEN_W-1:0] wr_th;
    logic [TOKEN_W-1:0] wr_tl;
    logic [TIME_W-1:0]  wr_la;
    t_valid_op          vop;
    logic [IW-1:0]      v_idx;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = idle;
    assign start           = i_s_axis_tvalid && idle;
    assign out_free        = !r_m_tvalid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = {7'd0, r_m_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            r_timeout <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (out_free) begin
            r_m_tvalid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_m_res <= res;
        end
    end

    sttu_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (i_s_axis_tuser),
        .i_now       (i_s_axis_tdata[31:0]),
        .i_th        (i_s_axis_tdata[95:32]),
        .i_tl        (i_s_axis_tdata[159:96]),
        .i_timeout   (r_timeout),
        .i_out_free  (out_free),
        .o_idle      (idle),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_rd_addr   (rd_addr),
        .i_rd_th     (rd_th),
        .i_rd_tl     (rd_tl),
        .i_rd_la     (rd_la),
        .i_valid     (valid),
        .o_wr_op     (wr_op),
        .o_wr_addr   (wr_addr),
        .o_wr_th     (wr_th),
        .o_wr_tl     (wr_tl),
        .o_wr_la     (wr_la),
        .o_vop       (vop),
        .o_v_idx     (v_idx)
    );

    sttu_store #(
        .SLOTS (SLOTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_th   (rd_th),
        .o_rd_tl   (rd_tl),
        .o_rd_la   (rd_la),
        .i_wr_op   (wr_op),
        .i_wr_addr (wr_addr),
        .i_wr_th   (wr_th),
        .i_wr_tl   (wr_tl),
        .i_wr_la   (wr_la),
        .i_vop     (vop),
        .i_v_idx   (v_idx),
        .o_valid   (valid)
    );

endmodule

`default_nettype wire

[sim/session_table_idle_timeout_unit_tb.sv]
// Testbench for session_table_idle_timeout_unit: directed table, then random
// session traffic under several idle timeouts, checked beat by beat against fixed
// results or an in-bench session table predictor. Depends on sttu_pkg and the unit's RTL.
`timescale 1ns / 1ps

module session_table_idle_timeout_unit_tb;
    import sttu_pkg::*;

    localparam int SLOTS = SLOTS_DEF;
    localparam int POOL = 12;
    localparam int SETTLE_CYCLES = SLOTS + 8;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned PHASE_ITEMS = 196;
    localparam logic [2:0] CMD_RSVD_LO = 3'd5;
    localparam logic [2:0] CMD_RSVD_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] now;
        logic [63:0] th;
        logic [63:0] tl;
        logic        fixed;
        t_result     res;
    } t_stim_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic [31:0]  i_cfg_data = '0;
    logic         i_s_axis_tvalid = 1'b0;
    logic [159:0] i_s_axis_tdata = '0;   // now_sec, token_high, token_low
    logic [2:0]   i_s_axis_tuser = '0;   // cmd
    logic         i_m_axis_tready = 1'b0;
    logic         o_cfg_ready;
    logic         o_s_axis_tready;
    logic         o_m_axis_tvalid;
    logic [15:0]  o_m_axis_tdata;        // ok, slot, evicted, active_count, zero pad

    session_table_idle_timeout_unit #(
        .SLOTS(SLOTS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .i_s_axis_tuser(i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // predicted table state
    logic [31:0] timeout_sec;
    logic        sess_valid [SLOTS];
    logic [63:0] sess_tok_hi [SLOTS];
    logic [63:0] sess_tok_lo [SLOTS];
    logic [31:0] sess_seen [SLOTS];

    t_result     expect_q [$];
    int unsigned mismatches = 0;
    int unsigned out_beats = 0;
    int unsigned cycle_cnt = 0;
    bit          idle_on = 1'b1;
    logic [31:0] clock_sec;
    logic [63:0] tok_hi_pool [POOL];
    logic [63:0] tok_lo_pool [POOL];
    t_stim_row   rows [0:23];

    function automatic void drop_session(int k);
        sess_valid[k] = 1'b0;
        sess_tok_hi[k] = '0;
        sess_tok_lo[k] = '0;
        sess_seen[k] = '0;
    endfunction

    function automatic logic session_idle(int k, logic [31:0] now);
        logic [31:0] idle;
        idle = now - sess_seen[k];
        return idle > timeout_sec;
    endfunction

    function automatic void expire_idle(logic [31:0] now);
        for (int k = 0; k < SLOTS; k++)
            if (sess_valid[k] && session_idle(k, now))
                drop_session(k);
    endfunction

    function automatic int find_session(logic [63:0] th, logic [63:0] tl);
        for (int k = 0; k < SLOTS; k++)
            if (sess_valid[k] && sess_tok_hi[k] == th && sess_tok_lo[k] == tl)
                return k;
        return -1;
    endfunction

    function automatic t_result session_step(logic [2:0] cmd, logic [31:0] now,
                                             logic [63:0] th, logic [63:0] tl);
        t_result r;
        int      s;
        int      n;
        r = '0;
        s = -1;
        n = 0;
        case (cmd)
            CMD_CREATE: begin
                expire_idle(now);
                for (int k = SLOTS - 1; k >= 0; k--)
                    if (!sess_valid[k])
                        s = k;
                if (s < 0) begin
                    s = 0;
                    for (int k = 1; k < SLOTS; k++)
                        if (sess_seen[k] < sess_seen[s])
                            s = k;
                    drop_session(s);
                    r.evicted = 1'b1;
                end
                sess_valid[s] = 1'b1;
                sess_tok_hi[s] = th;
                sess_tok_lo[s] = tl;
                sess_seen[s] = now;
                r.ok = 1'b1;
                r.slot = 3'(s);
            end
            CMD_VALIDATE: begin
                s = find_session(th, tl);
                if (s >= 0) begin
                    r.slot = 3'(s);
                    if (session_idle(s, now)) begin
                        drop_session(s);
                    end else begin
                        sess_seen[s] = now;
                        r.ok = 1'b1;
                    end
                end
            end
            CMD_DESTROY: begin
                s = find_session(th, tl);
                if (s >= 0) begin
                    drop_session(s);
                    r.ok = 1'b1;
                    r.slot = 3'(s);
                end
            end
            CMD_DESTROY_ALL: begin
                for (int k = 0; k < SLOTS; k++)
                    drop_session(k);
            end
            CMD_COUNT: begin
                expire_idle(now);
                for (int k = 0; k < SLOTS; k++)
                    if (sess_valid[k])
                        n++;
                r.count = (n > 15) ? 4'd15 : 4'(n);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string what, t_result want, t_result got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: exp ok=%0d slot=%0d evicted=%0d count=%0d, %s%0d %s%0d %s%0d %s%0d",
                     what, want.ok, want.slot, want.evicted, want.count,
                     "got ok=", got.ok, "slot=", got.slot,
                     "evicted=", got.evicted, "count=", got.count);
    endtask

    task automatic send_item(logic [2:0] cmd, logic [31:0] now, logic [63:0] th,
                             logic [63:0] tl, logic fixed, t_result fixed_res);
        t_result pred;
        if (idle_on && $urandom_range(0, 99) < 37) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {tl, th, now};
        i_s_axis_tuser <= cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pred = session_step(cmd, now, th, tl);
        expect_q.push_back(fixed ? fixed_res : pred);
    endtask

    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [31:0] value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        timeout_sec = value;
    endtask

    task automatic run_session_mix(int unsigned n_items);
        int unsigned r;
        int          k;
        logic [2:0]  cmd;
        logic [63:0] th;
        logic [63:0] tl;
        for (int unsigned n = 0; n < n_items; n++) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                clock_sec += $urandom_range(0, (timeout_sec >> 2) + 1);
            end else if (r < 85) begin
                // land right at or just past the idle limit of some entry
                k = $urandom_range(0, SLOTS - 1);
                clock_sec = sess_seen[k] + timeout_sec + $urandom_range(0, 1);
            end else if (r >= 95) begin
                clock_sec = $urandom();
            end
            r = $urandom_range(0, 99);
            if (r < 35)
                cmd = CMD_CREATE;
            else if (r < 65)
                cmd = CMD_VALIDATE;
            else if (r < 77)
                cmd = CMD_DESTROY;
            else if (r < 92)
                cmd = CMD_COUNT;
            else if (r < 95)
                cmd = CMD_DESTROY_ALL;
            else
                cmd = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
            k = $urandom_range(0, POOL - 1);
            th = tok_hi_pool[k];
            tl = tok_lo_pool[k];
            if ($urandom_range(0, 99) < 20) begin
                th = {$urandom(), $urandom()};
                tl = {$urandom(), $urandom()};
                if (cmd == CMD_CREATE) begin
                    tok_hi_pool[k] = th;
                    tok_lo_pool[k] = tl;
                end
            end
            send_item(cmd, clock_sec, th, tl, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: check each beat, then pick next tready
    initial begin : rx_side
        int unsigned hold_left;
        bit          held;
        t_result     got;
        t_result     want;
        hold_left = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_result'(o_m_axis_tdata[8:0]);
                out_beats++;
                if (expect_q.size() == 0) begin
                    report("unexpected beat", '0, got);
                end else begin
                    want = expect_q.pop_front();
                    if (got.ok !== want.ok || got.slot !== want.slot ||
                        got.evicted !== want.evicted || got.count !== want.count)
                        report("mismatch", want, got);
                end
            end
            if (!held && out_beats == 300) begin
                hold_left = 400;
                held = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 37);
            end
        end
    end

    initial begin : main_seq
        logic [31:0] timeouts [6];
        rows = '{
            '{CMD_COUNT,       32'd0,    64'd0, 64'd0, 1'b1, '{4'd0, 1'b0, 3'd0, 1'b0}},
            '{CMD_VALIDATE,    32'd10,   64'd0, 64'd0, 1'b1, '{4'd0, 1'b0, 3'd0, 1'b0}},
            '{CMD_DESTROY,     32'd20,   64'd0, 64'd0, 1'b1, '{4'd0, 1'b0, 3'd0, 1'b0}},
            '{CMD_CREATE,      32'd100,  64'd0, 64'd0, 1'b1, '{4'd0, 1'b0, 3'd0, 1'b1}},
            '{CMD_CREATE,      32'd200,  '1,    '1,    1'b1, '{4'd0, 1'b0, 3'd1, 1'b1}},
            '{CMD_VALIDATE,    32'd3700, 64'd0, 64'd0, 1'b1, '{4'd0, 1'b0, 3'd0, 1'b1}},
            '{CMD_VALIDATE,    32'd3801, '1,    '1,    1'b1, '{4'd0, 1'b0, 3'd1, 1'b0}},
            '{CMD_CREATE, 32'd4001, 64'h0123_4567_89AB_CD01, 64'hFEDC_BA98_7654_3201, 1'b0, '0},
            '{CMD_CREATE, 32'd4002, 64'h0123_4567_89AB_CD02, 64'hFEDC_BA98_7654_3202, 1'b0, '0},
            '{CMD_CREATE, 32'd4003, 64'h0123_4567_89AB_CD03, 64'hFEDC_BA98_7654_3203, 1'b0, '0},
            '{CMD_CREATE, 32'd4004, 64'h0123_4567_89AB_CD04, 64'hFEDC_BA98_7654_3204, 1'b0, '0},
            '{CMD_CREATE, 32'd4005, 64'h0123_4567_89AB_CD05, 64'hFEDC_BA98_7654_3205, 1'b0, '0},
            '{CMD_CREATE, 32'd4006, 64'h0123_4567_89AB_CD06, 64'hFEDC_BA98_7654_3206, 1'b0, '0},
            '{CMD_CREATE, 32'd4007, 64'h0123_4567_89AB_CD07, 64'hFEDC_BA98_7654_3207, 1'b0, '0},
            '{CMD_CREATE, 32'd4100, 64'hDEAD_BEEF_0000_0001, 64'h8000_0000_0000_0000, 1'b1,
              '{4'd0, 1'b1, 3'd0, 1'b1}},
            '{CMD_COUNT,       32'd4200, 64'd0, 64'd0, 1'b1, '{4'd8, 1'b0, 3'd0, 1'b0}},
            '{CMD_DESTROY, 32'd4250, 64'h0123_4567_89AB_CD04, 64'hFEDC_BA98_7654_3204, 1'b0, '0},
            '{CMD_RSVD_HI,     32'd4300, '1,    64'd0, 1'b1, '{4'd0, 1'b0, 3'd0, 1'b0}},
            '{CMD_DESTROY_ALL, 32'd4400, 64'd0, 64'd0, 1'b1, '{4'd0, 1'b0, 3'd0, 1'b0}},
            '{CMD_COUNT,       32'd4500, 64'd0, 64'd0, 1'b1, '{4'd0, 1'b0, 3'd0, 1'b0}},
            '{CMD_CREATE, 32'hFFFF_FFFF, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
              '{4'd0, 1'b0, 3'd0, 1'b1}},
            '{CMD_VALIDATE, 32'd5, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
              '{4'd0, 1'b0, 3'd0, 1'b1}},
            '{CMD_COUNT,       32'd3000, 64'd0, 64'd0, 1'b1, '{4'd1, 1'b0, 3'd0, 1'b0}},
            '{CMD_VALIDATE,    32'd3000, 64'd1, 64'd2, 1'b1, '{4'd0, 1'b0, 3'd0, 1'b0}}
        };
        timeouts = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd37, 32'($urandom_range(2, 100000)),
                     TIMEOUT_RESET};

        timeout_sec = TIMEOUT_RESET;
        for (int k = 0; k < SLOTS; k++)
            drop_session(k);
        for (int k = 0; k < POOL; k++) begin
            tok_hi_pool[k] = (k == 0) ? '0 : (k == 1) ? '1 : {$urandom(), $urandom()};
            tok_lo_pool[k] = (k == 0) ? '0 : (k == 1) ? '1 : {$urandom(), $urandom()};
        end
        clock_sec = $urandom();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[n])
            send_item(rows[n].cmd, rows[n].now, rows[n].th, rows[n].tl,
                      rows[n].fixed, rows[n].res);

        run_session_mix(PHASE_ITEMS);
        foreach (timeouts[p]) begin
            write_timeout(timeouts[p]);
            idle_on = (p != 2);
            run_session_mix(PHASE_ITEMS);
        end
        idle_on = 1'b1;

        settle();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
